// ===== rtl/core/assert_macros.svh =====
// Assertion macros; the bodies expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/tdss_pkg.sv =====
package tdss_pkg;

	localparam int unsigned VALUE_W = 10;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned SEG_CLOCKS = 8;

	localparam logic [VALUE_W-1:0] MAX_VALUE = 10'd999;
	localparam logic [3:0]         BLANK_CODE = 4'd10;

	// v/100 ~ (v*41)>>12 and r/10 ~ (r*205)>>11 over the saturated range
	localparam logic [5:0] HUN_RECIP = 6'd41;
	localparam logic [7:0] TEN_RECIP = 8'd205;

	typedef struct packed {
		logic [7:0] hundreds;
		logic [7:0] tens;
		logic [7:0] units;
	} seg_pats_t;

	// bit 7 = H ... bit 0 = A, 1 = lit
	function automatic logic [7:0] seg_pattern(input logic [3:0] code);
		logic [7:0] pat;
		case (code)
			4'd0:    pat = 8'h3F;
			4'd1:    pat = 8'h06;
			4'd2:    pat = 8'h5B;
			4'd3:    pat = 8'h4F;
			4'd4:    pat = 8'h66;
			4'd5:    pat = 8'h6D;
			4'd6:    pat = 8'h7D;
			4'd7:    pat = 8'h07;
			4'd8:    pat = 8'h7F;
			4'd9:    pat = 8'h6F;
			default: pat = 8'h00;
		endcase
		return pat;
	endfunction

endpackage

// ===== rtl/core/three_digit_seven_segment_serializer.sv =====
// Shows a value of 0 to 999 on three seven-segment digits as eight serial words, segment H
// (decimal point, never lit) first, then G down to A; lines are active low, leading zeros
// blanked, values above 999 shown as 999, last_bit marks the eighth word. The bit counter
// of the shift stage steps through the words of a value; the next value is held in the
// input register and split into digits while the current one shifts out, so consecutive
// values stream without gaps when the output is not stalled.
module three_digit_seven_segment_serializer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tdss_pkg::VALUE_W-1:0] value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         line_units,
	output logic                         line_tens,
	output logic                         line_hundreds,
	output logic [tdss_pkg::IDX_W-1:0]   segment_index,
	output logic                         last_bit
);
	import tdss_pkg::*;

	logic [VALUE_W-1:0] value_s1;
	logic               valid_s1;
	logic               take;
	seg_pats_t          pats;

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			value_s1 <= value;
		end
	end

	tdss_split u_split (
		.value (value_s1),
		.pats  (pats)
	);

	tdss_shifter u_shifter (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_valid    (valid_s1),
		.load_pats     (pats),
		.take          (take),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.line_units    (line_units),
		.line_tens     (line_tens),
		.line_hundreds (line_hundreds),
		.segment_index (segment_index),
		.last_bit      (last_bit)
	);

endmodule

// ===== rtl/core/tdss_split.sv =====
module tdss_split (
	input  logic [tdss_pkg::VALUE_W-1:0] value,
	output tdss_pkg::seg_pats_t          pats
);
	import tdss_pkg::*;

	logic [VALUE_W-1:0] sat;
	logic [15:0]        hun_prod;
	logic [3:0]         hun;
	logic [VALUE_W-1:0] rem_full;
	logic [6:0]         rem;
	logic [14:0]        ten_prod;
	logic [3:0]         ten;
	logic [6:0]         uni_full;
	logic [3:0]         uni;
	logic [3:0]         ten_code;
	logic [3:0]         hun_code;

	assign sat      = (value > MAX_VALUE) ? MAX_VALUE : value;
	assign hun_prod = 16'(sat) * 16'(HUN_RECIP);
	assign hun      = hun_prod[15:12];
	assign rem_full = sat - (VALUE_W'(hun) * VALUE_W'(100));
	assign rem      = rem_full[6:0];
	assign ten_prod = 15'(rem) * 15'(TEN_RECIP);
	assign ten      = ten_prod[14:11];
	assign uni_full = rem - (7'(ten) * 7'd10);
	assign uni      = uni_full[3:0];

	assign hun_code = (hun != 4'd0) ? hun : BLANK_CODE;
	assign ten_code = (hun != 4'd0 || ten != 4'd0) ? ten : BLANK_CODE;

	assign pats.hundreds = seg_pattern(hun_code);
	assign pats.tens     = seg_pattern(ten_code);
	assign pats.units    = seg_pattern(uni);

endmodule

// ===== rtl/core/tdss_shifter.sv =====
`include "assert_macros.svh"

module tdss_shifter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load_valid,
	input  tdss_pkg::seg_pats_t        load_pats,
	output logic                       take,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       line_units,
	output logic                       line_tens,
	output logic                       line_hundreds,
	output logic [tdss_pkg::IDX_W-1:0] segment_index,
	output logic                       last_bit
);
	import tdss_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEG_CLOCKS - 1);

	seg_pats_t        pat_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] bit_sel;

	assign last_bit = (idx_q == LAST_IDX);
	assign take     = !busy_q || (!out_stall && last_bit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= load_valid;
			idx_q  <= '0;
		end else if (!out_stall) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take && load_valid) begin
			pat_q <= load_pats;
		end
	end

	// H goes first: segment index 0 reads pattern bit 7
	assign bit_sel       = ~idx_q;
	assign out_valid     = busy_q;
	assign segment_index = idx_q;
	assign line_units    = ~pat_q.units[bit_sel];
	assign line_tens     = ~pat_q.tens[bit_sel];
	assign line_hundreds = ~pat_q.hundreds[bit_sel];

	`ASSERT_IMP(a_idle_idx_zero, !busy_q, idx_q == '0)
	`ASSERT_NEXT(a_hold_on_stall, busy_q && out_stall, busy_q && $stable(idx_q))
	`ASSERT_NEXT(a_step, busy_q && !out_stall && !last_bit,
		busy_q && idx_q == $past(idx_q) + IDX_W'(1))
	`ASSERT_NEXT(a_load_starts, take && load_valid, busy_q && idx_q == '0)

endmodule

// ===== verif/three_digit_seven_segment_serializer_tb.sv =====
module three_digit_seven_segment_serializer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned VW = tdss_pkg::VALUE_W;
	localparam int unsigned IW = tdss_pkg::IDX_W;
	localparam int unsigned NCLK = tdss_pkg::SEG_CLOCKS;
	localparam logic [7:0] BLANK_GLYPH = 8'h00;

	typedef struct packed {
		logic          units;
		logic          tens;
		logic          hundreds;
		logic [IW-1:0] index;
		logic          last_flag;
	} shift_word_t;

	// bit 7 = H ... bit 0 = A, 1 = lit
	localparam logic [7:0] DIGIT_GLYPH [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	logic          clk;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [VW-1:0] value = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic          line_units;
	logic          line_tens;
	logic          line_hundreds;
	logic [IW-1:0] segment_index;
	logic          last_bit;

	logic [VW-1:0] pending_values [$];
	shift_word_t   expected_words [$];
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            error_count = 0;
	int            values_sent = 0;
	int            words_checked = 0;

	three_digit_seven_segment_serializer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_units   (line_units),
		.line_tens    (line_tens),
		.line_hundreds(line_hundreds),
		.segment_index(segment_index),
		.last_bit     (last_bit)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void queue_shift_words(input logic [VW-1:0] raw);
		int unsigned v, hun, ten, uni;
		logic [7:0]  p_u, p_t, p_h;
		shift_word_t w;
		v = (raw > tdss_pkg::MAX_VALUE) ? tdss_pkg::MAX_VALUE : raw;
		hun = v / 100;
		ten = (v % 100) / 10;
		uni = v % 10;
		p_u = DIGIT_GLYPH[uni];
		p_t = (hun != 0 || ten != 0) ? DIGIT_GLYPH[ten] : BLANK_GLYPH;
		p_h = (hun != 0) ? DIGIT_GLYPH[hun] : BLANK_GLYPH;
		for (int b = 0; b < NCLK; b++) begin
			w.units     = ~p_u[7-b];
			w.tens      = ~p_t[7-b];
			w.hundreds  = ~p_h[7-b];
			w.index     = IW'(b);
			w.last_flag = (b == NCLK - 1);
			expected_words.push_back(w);
		end
	endfunction

	task automatic check_word;
		shift_word_t e;
		if (expected_words.size() == 0) begin
			report_mismatch("output word with nothing expected");
			return;
		end
		e = expected_words.pop_front();
		words_checked++;
		if (line_units !== e.units)
			report_mismatch($sformatf("line_units %b, expected %b", line_units, e.units));
		if (line_tens !== e.tens)
			report_mismatch($sformatf("line_tens %b, expected %b", line_tens, e.tens));
		if (line_hundreds !== e.hundreds)
			report_mismatch($sformatf("line_hundreds %b, expected %b",
				line_hundreds, e.hundreds));
		if (segment_index !== e.index)
			report_mismatch($sformatf("segment_index %0d, expected %0d",
				segment_index, e.index));
		if (last_bit !== e.last_flag)
			report_mismatch($sformatf("last_bit %b, expected %b", last_bit, e.last_flag));
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				queue_shift_words(value);
				values_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_values.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					value <= pending_values.pop_front();
				end else begin
					in_valid <= 1'b0;
					value <= VW'($urandom_range(1023));
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_word();
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic add_random(input int n);
		logic [VW-1:0] v;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: v = VW'($urandom_range(9));
				1: v = VW'($urandom_range(99, 10));
				2: v = VW'($urandom_range(1023, 1000));
				default: v = VW'($urandom_range(1023));
			endcase
			pending_values.push_back(v);
		end
	endtask

	task automatic drain;
		while (pending_values.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int directed [];
		directed = '{
			0, 1, 7, 9, 10, 11, 20, 90, 99, 100, 101, 110, 200, 345,
			512, 678, 808, 888, 909, 998, 999, 1000, 1001, 1023
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			pending_values.push_back(VW'(directed[i]));
		add_random(50);
		drain();

		send_idle_pct = 70;
		recv_stall_pct = 0;
		add_random(50);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 70;
		add_random(50);
		drain();

		send_idle_pct = 11;
		recv_stall_pct = 11;
		add_random(50);
		drain();

		repeat (20) @(posedge clk);
		$display("%0d values shown (blanking, saturation, all digits) as %0d shift words",
			values_sent, words_checked);
		$display("under free-running, sender-idle, receiver-stall and mixed flow");
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
